>>> rtl/dmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_pkg
// shared types and constants of the dense matrix multiplier
// ----------------------------------------------------------------------------
package dmm_pkg;

   // default sizes
   localparam int MAX_DIM_DEF   = 8;
   localparam int FRAC_BITS_DEF = 16;

   // field widths
   localparam int DATA_W      = 32;
   localparam int FIELD_IDX_W = 3;
   localparam int DIM_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CMD_W       = 2;

   // packed stream widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_RUN    = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // control travelling with each multiply-accumulate step
   typedef struct packed {
      logic                   valid;
      logic [FIELD_IDX_W-1:0] row;
      logic [FIELD_IDX_W-1:0] col;
      logic                   first;   // first term of the element
      logic                   lastj;   // last term of the element
      logic                   last;    // final element of the run
   } tag_type;

endpackage
`default_nettype wire

>>> rtl/dmm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dmm_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/dense_matrix_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// fixed-point dense matrix product c = a x b over two element stores
// ----------------------------------------------------------------------------
// usage
//   csr channel: write rows_a, inner_dim and cols_b (index 0, 1, 2) while the
//   block is idle; 0 reads as 1, values above MAX_DIM read as MAX_DIM
//   req channel: a load-a or load-b request writes one element (row, col,
//   value) into its store; a run request streams every element
//   of c in row-major order on the rsp channel, tlast on the final one
//   throughput: one multiply-accumulate per cycle through the single
//   multiplier unless the output stalls, one read port per store, so each
//   element of c takes inner_dim terms and a run issues rows_a * cols_b *
//   inner_dim terms; a request is taken again once the run has finished
//   issuing
//   reset: dimension registers return to 1, pipeline and output empty; the
//   stores are not cleared and must be loaded before they are read
//   stall: when a result waits in the output register and rsp_tready is low
//   the whole multiply pipeline holds, nothing is lost or repeated
// ----------------------------------------------------------------------------
module dense_matrix_multiply #(
   parameter int MAX_DIM   = dmm_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = dmm_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // row [2:0], col [5:3], value [37:6], zero [39:38]
   input  wire logic [dmm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command [1:0]
   input  wire logic [dmm_pkg::CMD_W-1:0]       req_tuser,
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // out_row [2:0], out_col [5:3], product [37:6], zero [39:38]
   output logic      [dmm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // saturated [0]
   output logic      [dmm_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                                 rsp_tlast,
   // register write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [dmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dmm_pkg::DIM_W-1:0]       csr_data
);

   import dmm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_DIM);

   // request fields
   logic [FIELD_IDX_W-1:0] req_row;
   logic [FIELD_IDX_W-1:0] req_col;
   logic [DATA_W-1:0]      req_value;
   cmd_type                req_cmd;
   logic                   req_take;
   logic                   load_ok;

   // dimension registers
   logic [DIM_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [DIM_W-1:0] csr_dim;

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             end_j, end_k, end_i;
   tag_type          issue_tag;

   // pipeline
   logic                     advance;
   tag_type                  s1_ff, s2_ff, s3_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_ext, acc_shift;

   // stores
   logic              a_we, b_we;
   logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic [DATA_W-1:0] a_rd_data, b_rd_data;

   // output register
   logic                   rsp_valid_ff;
   logic [FIELD_IDX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [DATA_W-1:0]      rsp_prod_ff, fin_value;
   logic                   rsp_sat_ff, rsp_last_ff, fin_sat;

   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[37:6];
   assign req_cmd   = cmd_type'(req_tuser);
   assign req_take  = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // register port, always ready
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_data == '0) begin
         csr_dim = DIM_W'(1);
      end else if (csr_data > DIM_W'(MAX_DIM)) begin
         csr_dim = DIM_W'(MAX_DIM);
      end else begin
         csr_dim = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(1);
         inner_ff <= DIM_W'(1);
         cols_ff  <= DIM_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_A:    rows_ff  <= csr_dim;
            CSR_INNER_DIM: inner_ff <= csr_dim;
            CSR_COLS_B:    cols_ff  <= csr_dim;
            default:       ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // element stores, written by loads, read by the sequencer
   // ------------------------------------------------------------------------
   // loads only land while idle, so no write can meet a read in flight
   assign load_ok = ({1'b0, req_row} < (FIELD_IDX_W + 1)'(MAX_DIM)) &&
                    ({1'b0, req_col} < (FIELD_IDX_W + 1)'(MAX_DIM));
   assign wr_addr = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(MAX_DIM) + ADDR_W'(req_col));
   assign a_we    = req_take && load_ok && (req_cmd == CMD_LOAD_A);
   assign b_we    = req_take && load_ok && (req_cmd == CMD_LOAD_B);

   // a[i][j] and b[j][k]
   assign a_rd_addr = ADDR_W'(ADDR_W'(i_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(j_ff));
   assign b_rd_addr = ADDR_W'(ADDR_W'(j_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff));

   dmm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (advance),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   dmm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (advance),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // ------------------------------------------------------------------------
   // sequencer: walks i, k, j (holding while the output stalls), one term per cycle
   // ------------------------------------------------------------------------
   // the pipeline moves unless a finished result is stuck at the output
   assign advance = !rsp_valid_ff || rsp_tready;

   assign end_j = (DIM_W'(j_ff) == inner_ff - DIM_W'(1));
   assign end_k = (DIM_W'(k_ff) == cols_ff - DIM_W'(1));
   assign end_i = (DIM_W'(i_ff) == rows_ff - DIM_W'(1));

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take && (req_cmd == CMD_RUN)) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (!end_j) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!end_k) begin
                     k_in = k_ff + IDX_W'(1);
                  end else begin
                     k_in = '0;
                     if (!end_i) begin
                        i_in = i_ff + IDX_W'(1);
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      issue_tag       = '0;
      issue_tag.valid = (state_ff == ST_RUN);
      issue_tag.row   = FIELD_IDX_W'(i_ff);
      issue_tag.col   = FIELD_IDX_W'(k_ff);
      issue_tag.first = (j_ff == '0);
      issue_tag.lastj = end_j;
      issue_tag.last  = end_i && end_k;
   end

   // ------------------------------------------------------------------------
   // read, multiply, accumulate
   // ------------------------------------------------------------------------
   assign prod_in  = $signed(a_rd_data) * $signed(b_rd_data);
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = s2_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else if (advance) begin
         s1_ff <= issue_tag;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         if (s2_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // scale back by the fraction bits (floor) and clip to 32 bits
   // ------------------------------------------------------------------------
   assign acc_shift = acc_ff >>> FRAC_BITS;

   always_comb begin
      if ((acc_shift[ACC_W-1:DATA_W-1] == '0) || (acc_shift[ACC_W-1:DATA_W-1] == '1)) begin
         fin_sat   = 1'b0;
         fin_value = acc_shift[DATA_W-1:0];
      end else begin
         fin_sat   = 1'b1;
         fin_value = acc_ff[ACC_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                     : {1'b0, {(DATA_W - 1){1'b1}}};
      end
   end

   // ------------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s3_ff.valid && s3_ff.lastj) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s3_ff.valid && s3_ff.lastj) begin
         rsp_row_ff  <= s3_ff.row;
         rsp_col_ff  <= s3_ff.col;
         rsp_prod_ff <= fin_value;
         rsp_sat_ff  <= fin_sat;
         rsp_last_ff <= s3_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_prod_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a finished element reaches the output register in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (advance && s3_ff.valid && s3_ff.lastj) |=> rsp_valid_ff)
      else $error("finished element did not reach the output register");

   // a stall freezes the accumulator
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff) && $stable(s3_ff))
      else $error("accumulator moved during a stall");

   // a clipped result holds one of the two limits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_prod_ff == 32'h7fff_ffff) || (rsp_prod_ff == 32'h8000_0000))
      else $error("saturated result is not a limit value");
`endif

endmodule
`default_nettype wire
